// ===== hw/rtl/rfd_pkg.sv =====
// Shared types and constants for the radio frame deframer.
`default_nettype none

package rfd_pkg;

   localparam int unsigned HeaderBytes = 7;
   localparam int unsigned AddrWidth   = 24;
   localparam int unsigned CsrIdxWidth = 2;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_REJECT  = 2'd2
   } kind_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_NODE_ADDR  = 2'd0,
      CSR_BCAST_ADDR = 2'd1,
      CSR_PROMISC    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [AddrWidth-1:0] node_address;
      logic [AddrWidth-1:0] broadcast_address;
      logic                 promiscuous;
   } cfg_type;

   typedef struct packed {
      kind_type             kind;
      logic [7:0]           data_byte;
      logic                 last;
      logic [AddrWidth-1:0] source_address;
      logic                 ack_req;
      logic                 ack_rcvd;
      logic                 ack_needed;
      logic [5:0]           payload_length;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rfd_parser.sv =====
// Frame parser: header state, address filter and per-byte result generation.
`default_nettype none

module rfd_parser #(
   parameter int unsigned MAX_FRAME_LENGTH = 66
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          rx_byte,
   input  wire logic                frame_start,
   input  wire rfd_pkg::cfg_type    cfg,
   output logic                     res_valid,
   output rfd_pkg::result_type      res
);

   localparam logic [6:0] MaxLen = 7'(MAX_FRAME_LENGTH);
   localparam logic [6:0] HdrLen = 7'(rfd_pkg::HeaderBytes);

   logic                            in_frame_ff, in_frame_in;
   logic [6:0]                      pos_ff, pos_in;
   logic [6:0]                      len_ff, len_in;
   logic [rfd_pkg::AddrWidth-1:0]   dest_ff, dest_in;
   logic [rfd_pkg::AddrWidth-1:0]   src_ff, src_in;
   logic [1:0]                      ctl_ff, ctl_in;

   logic [6:0] pos_inc;
   logic       addr_ok;
   logic       full;
   logic [1:0] ctl_emit;

   assign pos_inc = pos_ff + 7'd1;

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      dest_in     = dest_ff;
      src_in      = src_ff;
      ctl_in      = ctl_ff;
      res_valid   = 1'b0;
      full        = 1'b0;
      ctl_emit    = ctl_ff;
      addr_ok     = 1'b0;
      res         = '0;
      res.kind    = rfd_pkg::KIND_PAYLOAD;
      if (step) begin
         if (frame_start) begin
            len_in      = (rx_byte > {1'b0, MaxLen}) ? MaxLen : rx_byte[6:0];
            in_frame_in = 1'b1;
            pos_in      = '0;
            dest_in     = '0;
            src_in      = '0;
            ctl_in      = '0;
         end else if (in_frame_ff) begin
            pos_in = pos_inc;
            if (pos_inc <= 7'd3) begin
               dest_in = {dest_ff[15:0], rx_byte};
               if (pos_inc == 7'd3) begin
                  addr_ok = cfg.promiscuous || (dest_in == cfg.node_address) ||
                            (dest_in == cfg.broadcast_address);
                  if (!addr_ok || (len_ff < HdrLen)) begin
                     in_frame_in = 1'b0;
                     res_valid   = 1'b1;
                     res.kind    = rfd_pkg::KIND_REJECT;
                     res.last    = 1'b1;
                  end
               end
            end else if (pos_inc <= 7'd6) begin
               src_in = {src_ff[15:0], rx_byte};
            end else if (pos_inc == HdrLen) begin
               ctl_in   = {rx_byte[7], rx_byte[6]};
               ctl_emit = ctl_in;
               if (len_ff == HdrLen) begin
                  in_frame_in = 1'b0;
                  res_valid   = 1'b1;
                  full        = 1'b1;
                  res.kind    = rfd_pkg::KIND_EMPTY;
                  res.last    = 1'b1;
               end
            end else begin
               res_valid     = 1'b1;
               full          = 1'b1;
               res.kind      = rfd_pkg::KIND_PAYLOAD;
               res.data_byte = rx_byte;
               res.last      = (pos_inc >= len_ff);
               if (pos_inc >= len_ff) begin
                  in_frame_in = 1'b0;
               end
            end
         end
      end
      if (full) begin
         res.source_address = src_ff;
         res.ack_req        = ctl_emit[0];
         res.ack_rcvd       = ctl_emit[1];
         res.ack_needed     = ctl_emit[0] && !ctl_emit[1];
         res.payload_length = 6'(len_ff - HdrLen);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         len_ff      <= '0;
         dest_ff     <= '0;
         src_ff      <= '0;
         ctl_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         dest_ff     <= dest_in;
         src_ff      <= src_in;
         ctl_ff      <= ctl_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/radio_frame_deframer_core.sv =====
// Radio frame deframer: parses received frame bytes into payload results.
//
// Request channel (req_*): one received byte per request; req_frame_start
// marks the length byte that opens a frame. Response channel (rsp_*): at most
// one response per request: a payload byte with its last marker, an accepted
// empty frame, or a rejected frame. Payload and empty responses carry the
// source address, ack flags and payload length of their frame; a reject
// carries zeros there. Other header bytes, stray and restart bytes produce
// no response. A response is valid the cycle after its request is accepted.
// Throughput: one request per cycle while req_ready is high; the parser is a
// single compare/shift stage feeding one response register.
// req_ready is high while the response register is empty or being drained,
// so a stalled receiver holds the response and back-pressures the sender
// only while the held response is not taken.
// Reset clears the parser to idle, empties the response register and sets
// node address 0, broadcast address 0xFFFFFF, promiscuous mode off.
// The csr_* port writes a register at each edge with csr_we high; write it
// only while the block is idle.
`default_nettype none

module radio_frame_deframer_core #(
   parameter int unsigned MAX_FRAME_LENGTH = 66
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_rx_byte,
   input  wire logic                            req_frame_start,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [1:0]                           rsp_kind,
   output logic [7:0]                           rsp_data_byte,
   output logic                                 rsp_last,
   output logic [rfd_pkg::AddrWidth-1:0]        rsp_source_address,
   output logic                                 rsp_ack_req,
   output logic                                 rsp_ack_rcvd,
   output logic                                 rsp_ack_needed,
   output logic [5:0]                           rsp_payload_length,
   input  wire logic                            csr_we,
   input  wire logic [rfd_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [rfd_pkg::AddrWidth-1:0]   csr_wdata
);

   rfd_pkg::cfg_type    cfg_ff, cfg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rfd_pkg::result_type rsp_ff, rsp_in;
   logic                step;
   logic                res_valid;
   rfd_pkg::result_type res;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (rfd_pkg::csr_index_type'(csr_index))
            rfd_pkg::CSR_NODE_ADDR:  cfg_in.node_address      = csr_wdata;
            rfd_pkg::CSR_BCAST_ADDR: cfg_in.broadcast_address = csr_wdata;
            rfd_pkg::CSR_PROMISC:    cfg_in.promiscuous       = csr_wdata[0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   rfd_parser #(
      .MAX_FRAME_LENGTH(MAX_FRAME_LENGTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (req_rx_byte),
      .frame_start (req_frame_start),
      .cfg         (cfg_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_ready) begin
         rsp_valid_in = res_valid;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_address      <= '0;
         cfg_ff.broadcast_address <= '1;
         cfg_ff.promiscuous       <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_data_byte      = rsp_ff.data_byte;
   assign rsp_last           = rsp_ff.last;
   assign rsp_source_address = rsp_ff.source_address;
   assign rsp_ack_req        = rsp_ff.ack_req;
   assign rsp_ack_rcvd       = rsp_ff.ack_rcvd;
   assign rsp_ack_needed     = rsp_ff.ack_needed;
   assign rsp_payload_length = rsp_ff.payload_length;

   a_start_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_frame_start) |=> !rsp_valid)
      else $error("frame start request produced a response");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == rfd_pkg::KIND_REJECT) |->
         (rsp_last && rsp_source_address == '0 && rsp_payload_length == '0 &&
          !rsp_ack_req && !rsp_ack_rcvd))
      else $error("rejected frame response carries frame data");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != rfd_pkg::KIND_PAYLOAD) |->
         (rsp_last && rsp_data_byte == 8'd0))
      else $error("non-payload response not final or carries data");

   a_ack_needed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ack_needed == (rsp_ack_req && !rsp_ack_rcvd)))
      else $error("ack_needed inconsistent with ack flags");

endmodule

`default_nettype wire

// ===== sim/tb_radio_frame_deframer_core.sv =====
// Self-checking testbench for radio_frame_deframer_core with a built-in frame parser model.
module tb_radio_frame_deframer_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MaxFrameLength = 66;
   localparam int unsigned CycleLimit     = 200000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [7:0]                      req_rx_byte = 8'h00;
   logic                            req_frame_start = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [1:0]                      rsp_kind;
   logic [7:0]                      rsp_data_byte;
   logic                            rsp_last;
   logic [rfd_pkg::AddrWidth-1:0]   rsp_source_address;
   logic                            rsp_ack_req;
   logic                            rsp_ack_rcvd;
   logic                            rsp_ack_needed;
   logic [5:0]                      rsp_payload_length;
   logic                            csr_we = 1'b0;
   logic [rfd_pkg::CsrIdxWidth-1:0] csr_index = rfd_pkg::CSR_NODE_ADDR;
   logic [rfd_pkg::AddrWidth-1:0]   csr_wdata = '0;

   // parser model state and register copies
   logic                            fr_open = 1'b0;
   logic [6:0]                      fr_pos = '0;
   logic [6:0]                      fr_len = '0;
   logic [rfd_pkg::AddrWidth-1:0]   fr_dest = '0;
   logic [rfd_pkg::AddrWidth-1:0]   fr_src = '0;
   logic                            fr_ack_req = 1'b0;
   logic                            fr_ack_rcv = 1'b0;
   logic [rfd_pkg::AddrWidth-1:0]   cfg_node = '0;
   logic [rfd_pkg::AddrWidth-1:0]   cfg_bcast = '1;
   logic                            cfg_promisc = 1'b0;

   rfd_pkg::result_type    pending_results[$];
   int unsigned            mismatches = 0;
   int unsigned            bytes_sent = 0;
   int unsigned            cycle_count = 0;
   int unsigned            snd_idle_pct = 0;
   int unsigned            rsp_idle_pct = 0;
   int unsigned            hold_left = 0;

   radio_frame_deframer_core #(
      .MAX_FRAME_LENGTH(MaxFrameLength)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last           (rsp_last),
      .rsp_source_address (rsp_source_address),
      .rsp_ack_req        (rsp_ack_req),
      .rsp_ack_rcvd       (rsp_ack_rcvd),
      .rsp_ack_needed     (rsp_ack_needed),
      .rsp_payload_length (rsp_payload_length),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic rfd_pkg::result_type frame_result(rfd_pkg::kind_type k,
                                                        logic [7:0] d, logic l,
                                                        logic full);
      rfd_pkg::result_type r;
      logic [6:0] body;
      body = fr_len - 7'(rfd_pkg::HeaderBytes);
      r.kind           = k;
      r.data_byte      = d;
      r.last           = l;
      r.source_address = full ? fr_src : '0;
      r.ack_req        = full & fr_ack_req;
      r.ack_rcvd       = full & fr_ack_rcv;
      r.ack_needed     = r.ack_req & ~r.ack_rcvd;
      r.payload_length = full ? body[5:0] : '0;
      return r;
   endfunction

   function automatic void deframe_byte(logic [7:0] b, logic s);
      logic addr_ok;
      logic is_last;
      if (s) begin
         fr_len     = (b > MaxFrameLength) ? 7'(MaxFrameLength) : b[6:0];
         fr_open    = 1'b1;
         fr_pos     = '0;
         fr_dest    = '0;
         fr_src     = '0;
         fr_ack_req = 1'b0;
         fr_ack_rcv = 1'b0;
         return;
      end
      if (!fr_open) return;
      fr_pos = fr_pos + 7'd1;
      if (fr_pos <= 7'd3) begin
         fr_dest = {fr_dest[15:0], b};
         addr_ok = cfg_promisc || fr_dest == cfg_node || fr_dest == cfg_bcast;
         if (fr_pos == 7'd3 && (!addr_ok || fr_len < 7'(rfd_pkg::HeaderBytes))) begin
            fr_open = 1'b0;
            pending_results.push_back(
               frame_result(rfd_pkg::KIND_REJECT, 8'h00, 1'b1, 1'b0));
         end
      end else if (fr_pos <= 7'd6) begin
         fr_src = {fr_src[15:0], b};
      end else if (fr_pos == 7'(rfd_pkg::HeaderBytes)) begin
         fr_ack_req = b[6];
         fr_ack_rcv = b[7];
         if (fr_len == 7'(rfd_pkg::HeaderBytes)) begin
            fr_open = 1'b0;
            pending_results.push_back(
               frame_result(rfd_pkg::KIND_EMPTY, 8'h00, 1'b1, 1'b1));
         end
      end else begin
         is_last = (fr_pos >= fr_len);
         if (is_last) fr_open = 1'b0;
         pending_results.push_back(frame_result(rfd_pkg::KIND_PAYLOAD, b, is_last, 1'b1));
      end
   endfunction

   function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rfd_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, expected none actual kind %0d data %0h",
                     $time, rsp_kind, rsp_data_byte);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", 24'(want.kind), 24'(rsp_kind));
            check_field("data_byte", 24'(want.data_byte), 24'(rsp_data_byte));
            check_field("last", 24'(want.last), 24'(rsp_last));
            check_field("source_address", want.source_address, rsp_source_address);
            check_field("ack_req", 24'(want.ack_req), 24'(rsp_ack_req));
            check_field("ack_rcvd", 24'(want.ack_rcvd), 24'(rsp_ack_rcvd));
            check_field("ack_needed", 24'(want.ack_needed), 24'(rsp_ack_needed));
            check_field("payload_length", 24'(want.payload_length),
                        24'(rsp_payload_length));
         end
      end
   end

   // leaves req_valid high on return; callers that stop sending lower it
   task automatic send_byte(input logic [7:0] b, input logic s);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= b;
      req_frame_start <= s;
      do @(posedge clock); while (!req_ready);
      deframe_byte(b, s);
      bytes_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_config(input logic [23:0] node, input logic [23:0] bcast,
                             input logic promisc);
      csr_we    <= 1'b1;
      csr_index <= rfd_pkg::CSR_NODE_ADDR;
      csr_wdata <= node;
      @(posedge clock);
      csr_index <= rfd_pkg::CSR_BCAST_ADDR;
      csr_wdata <= bcast;
      @(posedge clock);
      csr_index <= rfd_pkg::CSR_PROMISC;
      csr_wdata <= {23'd0, promisc};
      @(posedge clock);
      csr_we      <= 1'b0;
      cfg_node    = node;
      cfg_bcast   = bcast;
      cfg_promisc = promisc;
   endtask

   // length byte, then count bytes of header and random payload
   task automatic push_frame(input logic [7:0] len_byte, input logic [23:0] dest,
                             input logic [23:0] src, input logic [7:0] ctrl,
                             input int unsigned count);
      logic [7:0] b;
      send_byte(len_byte, 1'b1);
      for (int i = 1; i <= count; i++) begin
         if (i <= 3) b = dest[8*(3-i) +: 8];
         else if (i <= 6) b = src[8*(6-i) +: 8];
         else if (i == 7) b = ctrl;
         else b = 8'($urandom);
         send_byte(b, 1'b0);
      end
   endtask

   task automatic send_random_frame();
      int unsigned pick;
      int unsigned span;
      logic [7:0]  len_byte;
      logic [23:0] dest;
      pick = $urandom_range(99);
      if (pick < 75) len_byte = 8'($urandom_range(16, 7));
      else if (pick < 85) len_byte = 8'($urandom_range(6, 0));
      else if (pick < 95) len_byte = 8'($urandom_range(66, 17));
      else len_byte = 8'($urandom_range(255, 67));
      span = (len_byte > MaxFrameLength) ? MaxFrameLength : len_byte;
      if (span < 3) span = 3;
      pick = $urandom_range(99);
      if (pick < 45) dest = cfg_node;
      else if (pick < 75) dest = cfg_bcast;
      else dest = 24'($urandom);
      pick = $urandom_range(99);
      if (pick < 8) span = $urandom_range(span - 1, 0);
      push_frame(len_byte, dest, 24'($urandom), 8'($urandom), span);
      if (pick >= 92) begin
         repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
      end
   endtask

   task automatic test_directed();
      send_byte(8'hA5, 1'b0);
      push_frame(8'd8, 24'h000000, 24'hFFFFFF, 8'h40, 8);
      push_frame(8'd7, 24'hFFFFFF, 24'h000000, 8'hC0, 7);
      push_frame(8'd0, 24'h000000, 24'h000000, 8'h00, 3);
      send_byte(8'hFF, 1'b1);
      push_frame(8'd9, 24'h000000, 24'hABCDEF, 8'h80, 9);
      wait_idle();
   endtask

   task automatic test_addressing();
      set_config(24'hFFFFFF, 24'h000000, 1'b0);
      push_frame(8'd8, 24'h000000, 24'h123456, 8'h40, 8);
      push_frame(8'd8, 24'hFFFFFF, 24'h654321, 8'h00, 8);
      push_frame(8'd8, 24'h5A5A5A, 24'h111111, 8'h40, 8);
      wait_idle();
      set_config(24'($urandom), 24'($urandom), 1'b1);
      push_frame(8'd8, 24'($urandom), 24'($urandom), 8'h40, 8);
      push_frame(8'd2, 24'($urandom), 24'($urandom), 8'h00, 3);
      wait_idle();
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned snd_pct,
                                      input int unsigned rsp_pct);
      int unsigned target;
      snd_idle_pct = snd_pct;
      rsp_idle_pct = rsp_pct;
      target = bytes_sent + count;
      while (bytes_sent < target) send_random_frame();
      wait_idle();
   endtask

   task automatic test_backpressure();
      snd_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_left    = 400;
      push_frame(8'd200, cfg_node, 24'($urandom), 8'h40, MaxFrameLength);
      wait_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      snd_idle_pct = 19;
      rsp_idle_pct = 76;
      test_directed();
      test_addressing();
      set_config(24'($urandom), 24'hFFFFFF, 1'b0);
      test_random_traffic(360, 19, 76);
      set_config(24'($urandom), 24'($urandom), 1'b0);
      test_random_traffic(360, 76, 19);
      test_backpressure();
      set_config(24'($urandom), 24'($urandom), 1'b1);
      test_random_traffic(360, 0, 0);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
